// ----- rtl/core/wgs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgs_pkg
// Shared constants, types and the arctangent table of the waypoint guidance
// sequencer.
// ----------------------------------------------------------------------------
package wgs_pkg;

    // mission store and vectoring sizes
    localparam int MAX_POINTS   = 64;
    localparam int CORDIC_STEPS = 16;
    localparam int PT_AW        = $clog2(MAX_POINTS);
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int DIFF_W       = 33;
    localparam int VEC_W        = 44;
    localparam int ANG_W        = 26;
    localparam int ACC_W        = 60;

    localparam logic [31:0]             INV_GAIN = 32'd2608131496;
    localparam logic signed [ANG_W-1:0] QUARTER  = 26'sd5898240;
    localparam logic signed [15:0]      HEAD_LIM = 16'sd23040;

    // request opcodes
    typedef enum logic [1:0] {
        OP_WAYPOINT = 2'd0,
        OP_STOP     = 2'd1,
        OP_SAMPLE   = 2'd2,
        OP_TICK     = 2'd3
    } t_opcode;

    // register indexes on the config port
    localparam logic [1:0] REG_CAPTURE = 2'd0;
    localparam logic [1:0] REG_SLIP    = 2'd1;
    localparam logic [1:0] REG_SPEED   = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // vectoring result
    typedef struct packed {
        logic [31:0]        distance;
        logic signed [15:0] heading;
    } t_vec_res;

    // one result item
    typedef struct packed {
        logic signed [15:0] heading;
        logic [11:0]        speed;
        logic signed [31:0] depth;
        logic               stopped;
        logic [31:0]        distance;
        logic [6:0]         target_number;
    } t_result;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/wgs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/wgs_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgs_cordic
// Iterative CORDIC vectoring unit: one rotation step a cycle, then the gain
// correction through one shared multiplier in two partial products.
// ----------------------------------------------------------------------------
module wgs_cordic (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [wgs_pkg::DIFF_W-1:0] i_dx,
    input  logic signed [wgs_pkg::DIFF_W-1:0] i_dy,
    output logic                             o_done,
    output wgs_pkg::t_vec_res                o_res
);
    import wgs_pkg::*;

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_ROT  = 5'b00010,
        C_MULH = 5'b00100,
        C_MULL = 5'b01000,
        C_FIN  = 5'b10000
    } t_cstate;

    t_cstate                 r_state;
    logic signed [VEC_W-1:0] r_x, r_y;
    logic signed [ANG_W-1:0] r_z;
    logic [STEP_W-1:0]       r_iter;
    logic                    r_zero;
    logic [ACC_W-1:0]        r_acc;
    logic                    r_done;
    t_vec_res                r_res;

    logic signed [VEC_W-1:0] w_sx, w_sy, w_xs, w_ys;
    logic [VEC_W-2:0]        w_ux;
    logic [26:0]             w_mul_a;
    logic [58:0]             w_prod;
    logic [ACC_W-1:0]        w_rnd;
    logic [35:0]             w_d;
    logic signed [ANG_W:0]   w_zr, w_h;
    logic signed [15:0]      w_head;

    // scaled input vector and shifted step terms
    assign w_sx = VEC_W'(i_dx) <<< 8;
    assign w_sy = VEC_W'(i_dy) <<< 8;
    assign w_xs = r_x >>> r_iter;
    assign w_ys = r_y >>> r_iter;

    // gain correction operands
    assign w_ux    = r_x[VEC_W-1] ? '0 : r_x[VEC_W-2:0];
    assign w_mul_a = (r_state == C_MULH) ? w_ux[VEC_W-2:16] : {11'd0, w_ux[15:0]};
    assign w_prod  = 59'(w_mul_a) * 59'(INV_GAIN);

    // rounding, saturation and heading
    assign w_rnd  = r_acc + (ACC_W'(1) << 23);
    assign w_d    = w_rnd[59:24];
    assign w_zr   = (ANG_W+1)'(r_z) + (ANG_W+1)'(256);
    assign w_h    = w_zr >>> 9;

    always_comb begin
        if (r_zero) begin
            w_head = '0;
        end else if (w_h > (ANG_W+1)'(HEAD_LIM)) begin
            w_head = HEAD_LIM;
        end else if (w_h < -(ANG_W+1)'(HEAD_LIM)) begin
            w_head = -HEAD_LIM;
        end else begin
            w_head = 16'(w_h);
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: if (i_start) r_state <= C_ROT;
                C_ROT:  if (r_iter == STEP_W'(CORDIC_STEPS - 1)) r_state <= C_MULH;
                C_MULH: r_state <= C_MULL;
                C_MULL: r_state <= C_FIN;
                C_FIN: begin
                    r_state <= C_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                r_iter <= '0;
                r_zero <= (i_dx == '0) && (i_dy == '0);
                if (w_sx < 0) begin
                    if (w_sy >= 0) begin
                        r_x <= w_sy;
                        r_y <= -w_sx;
                        r_z <= QUARTER;
                    end else begin
                        r_x <= -w_sy;
                        r_y <= w_sx;
                        r_z <= -QUARTER;
                    end
                end else begin
                    r_x <= w_sx;
                    r_y <= w_sy;
                    r_z <= '0;
                end
            end
            C_ROT: begin
                r_iter <= r_iter + 1'b1;
                if (r_y >= 0) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + atan_lut(5'(r_iter));
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - atan_lut(5'(r_iter));
                end
            end
            C_MULH: r_acc <= ACC_W'(w_prod);
            C_MULL: r_acc <= r_acc + ACC_W'(w_prod >> 16);
            C_FIN: begin
                r_res.distance <= (|w_d[35:32]) ? '1 : w_d[31:0];
                r_res.heading  <= w_head;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- rtl/core/waypoint_guidance_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_guidance_sequencer_top
// Waypoint mission store and guidance sequencer: steers to the current
// waypoint by CORDIC vectoring, advances on capture or slip, stops on end
// of mission, sample timeout or a stop request.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_opcode .. i_last_point
// output    out        o_valid / i_stall    o_heading .. o_target_number
// config    in         psel/penable/pwrite  paddr, pwdata, prdata
//
// a position sample that steers passes through the accept, one store read,
// 16 cordic steps, two partial products and a rounding step for the gain,
// one hand-off, one compare and one load of the output register; all other
// requests finish in the accept or go straight to the output register load
// o_stall is high while a request is in work; the output register lets the
// next request in while a result waits
// reset is synchronous and needs no clearing pass; store entries are
// undefined until written
// ----------------------------------------------------------------------------
module waypoint_guidance_sequencer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_target_depth,
    input  logic               i_first_point,
    input  logic               i_last_point,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_heading,
    output logic [11:0]        o_speed,
    output logic signed [31:0] o_depth,
    output logic               o_stopped,
    output logic [31:0]        o_distance,
    output logic [6:0]         o_target_number,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import wgs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_VEC  = 5'b00100,
        S_DEC  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state             r_state;
    logic [15:0]        r_cap, r_slip;
    logic [11:0]        r_speed;
    logic [7:0]         r_tmo;
    logic [CNT_W-1:0]   r_pc, r_ti;
    logic               r_active, r_ldv, r_seen;
    logic [31:0]        r_ld;
    logic [7:0]         r_ticks;
    logic signed [31:0] r_px, r_py;
    t_result            r_pend, r_out;
    logic               r_o_valid;

    logic               w_acc, w_cfg_wr, w_out_load, w_hit, w_cdone, w_wr_en;
    logic [CNT_W-1:0]   w_pc_base;
    logic [7:0]         w_ticks_n;
    logic [95:0]        w_rd;
    logic signed [DIFF_W-1:0] w_dx, w_dy;
    t_vec_res           w_vres;
    t_result            w_stop;

    assign w_acc      = i_valid && (r_state == S_IDLE);
    assign o_stall    = (r_state != S_IDLE);
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign w_out_load = (r_state == S_EMIT) && (!r_o_valid || !i_stall);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= 16'd512;
            r_slip  <= 16'd2560;
            r_speed <= '0;
            r_tmo   <= 8'd5;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_CAPTURE: r_cap   <= pwdata[15:0];
                REG_SLIP:    r_slip  <= pwdata[15:0];
                REG_SPEED:   r_speed <= pwdata[11:0];
                REG_TIMEOUT: r_tmo   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CAPTURE: prdata = {16'd0, r_cap};
            REG_SLIP:    prdata = {16'd0, r_slip};
            REG_SPEED:   prdata = {20'd0, r_speed};
            REG_TIMEOUT: prdata = {24'd0, r_tmo};
            default:     prdata = '0;
        endcase
    end

    // waypoint store
    assign w_pc_base = i_first_point ? '0 : r_pc;
    assign w_wr_en   = w_acc && (i_opcode == OP_WAYPOINT) && (w_pc_base < CNT_W'(MAX_POINTS));

    wgs_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_pc_base[PT_AW-1:0]),
        .i_wr_data ({i_pos_x, i_pos_y, i_target_depth}),
        .i_rd_addr (r_ti[PT_AW-1:0]),
        .o_rd_data (w_rd)
    );

    // target offset and vectoring unit
    assign w_dx = DIFF_W'($signed(w_rd[95:64])) - DIFF_W'(r_px);
    assign w_dy = DIFF_W'($signed(w_rd[63:32])) - DIFF_W'(r_py);

    wgs_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_READ),
        .i_dx    (w_dx),
        .i_dy    (w_dy),
        .o_done  (w_cdone),
        .o_res   (w_vres)
    );

    // capture or slip test
    assign w_hit = (w_vres.distance < 32'(r_cap)) ||
                   (r_ldv && (w_vres.distance > r_ld) && (w_vres.distance < 32'(r_slip)));

    assign w_ticks_n = (r_ticks == 8'hFF) ? r_ticks : r_ticks + 1'b1;

    always_comb begin
        w_stop               = '0;
        w_stop.stopped       = 1'b1;
        w_stop.target_number = 7'(r_ti);
    end

    // request sequencer and mission state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_ti     <= '0;
            r_active <= 1'b0;
            r_ld     <= '0;
            r_ldv    <= 1'b0;
            r_ticks  <= '0;
            r_seen   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (w_acc) begin
                    unique case (t_opcode'(i_opcode))
                        OP_WAYPOINT: begin
                            r_active <= 1'b0;
                            r_pc     <= (w_pc_base < CNT_W'(MAX_POINTS)) ?
                                        w_pc_base + 1'b1 : w_pc_base;
                            if (i_last_point) begin
                                r_ti     <= '0;
                                r_active <= 1'b1;
                                r_ld     <= '0;
                                r_ldv    <= 1'b0;
                            end
                        end
                        OP_STOP: begin
                            r_active <= 1'b0;
                            r_pc     <= '0;
                            r_state  <= S_EMIT;
                        end
                        OP_SAMPLE: begin
                            r_ticks <= '0;
                            r_seen  <= 1'b1;
                            if (r_active) begin
                                if (r_ti >= r_pc) begin
                                    r_active <= 1'b0;
                                    r_pc     <= '0;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                        end
                        OP_TICK: begin
                            r_ticks <= w_ticks_n;
                            if (r_active && r_seen && (w_ticks_n > r_tmo)) begin
                                r_active <= 1'b0;
                                r_pc     <= '0;
                                r_state  <= S_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
                S_READ: r_state <= S_VEC;
                S_VEC:  if (w_cdone) r_state <= S_DEC;
                S_DEC: begin
                    if (w_hit) begin
                        r_ti    <= r_ti + 1'b1;
                        r_ldv   <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ld    <= w_vres.distance;
                        r_ldv   <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: if (w_out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // sample position and pending result
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_pend <= w_stop;
        end else if (r_state == S_DEC) begin
            r_pend.heading       <= w_vres.heading;
            r_pend.speed         <= r_speed;
            r_pend.depth         <= $signed(w_rd[31:0]);
            r_pend.stopped       <= 1'b0;
            r_pend.distance      <= w_vres.distance;
            r_pend.target_number <= 7'(r_ti);
        end else if (r_state == S_IDLE) begin
            r_pend <= w_stop;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= r_pend;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_heading       = r_out.heading;
    assign o_speed         = r_out.speed;
    assign o_depth         = r_out.depth;
    assign o_stopped       = r_out.stopped;
    assign o_distance      = r_out.distance;
    assign o_target_number = r_out.target_number;

`ifndef SYNTHESIS
    // vectoring finishes only while the sequencer waits for it
    a_cdone_in_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cdone |-> (r_state == S_VEC))
        else $error("vectoring done outside wait state");

    // fill count never passes the store depth
    a_pc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    // a stop result carries an all-zero command
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && o_stopped) |-> (o_distance == '0 && o_heading == '0 &&
        o_speed == '0 && o_depth == '0))
        else $error("stop result with nonzero command");

    // a new result loads only into a free or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |=> !(r_state == S_IDLE && $past(r_state == S_EMIT)) ||
        $past(!r_o_valid || !i_stall))
        else $error("output overwritten while stalled");
`endif

endmodule
